/* hw/rtl/mss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg: shared types for the merge sorter
// Data type, the link passed between neighboring cells, the cell control
// bundle and the controller states.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // what one cell shows its neighbors
    typedef struct packed {
        logic  valid;
        logic  gt;      // empty, or holds a key strictly above the new one
        t_data data;
    } t_link;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  insert;
        logic  shift;
        t_data data;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage : mss_pkg
`default_nettype wire

/* hw/rtl/merge_sorter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sorter: stable ascending sorter for signed 32-bit values
// Values are inserted into a chain of SORT_DEPTH cells kept in order; the
// set is shifted out of the chain head after the final transaction.
//
// channel  direction  handshake          payload
// input    in         start / busy       i_value, i_final_item
// result   out        o_valid (strobe)   o_sorted_value, o_end_of_run, o_overflow
//
// Loading accepts a transaction on each start while not busy; its insert is
// registered in the chain. After the final transaction busy stays high until
// all n stored values are shifted out of cell 0, one result per cycle.
// Values beyond SORT_DEPTH are dropped and flag o_overflow for that set.
// Synchronous reset empties the chain and clears the count and flag.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module merge_sorter #(
    parameter int SORT_DEPTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  signed [31:0]  i_value,
    input  wire                 i_final_item,
    output logic                o_valid,
    output logic signed [31:0]  o_sorted_value,
    output logic                o_end_of_run,
    output logic                o_overflow
);
    import mss_pkg::*;

    localparam int CNT_W = $clog2(SORT_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SORT_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_drop, n_drop;
    logic             w_accept;
    t_cell_ctrl       w_ctrl;
    t_link            w_link [SORT_DEPTH];

    assign busy     = (r_state == ST_EMIT);
    assign w_accept = start && !busy;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_left       = r_left;
        n_drop       = r_drop;
        w_ctrl.insert = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_ctrl.data   = i_value;
        o_valid       = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (r_fill < DEPTH_C) begin
                        w_ctrl.insert = 1'b1;
                        n_fill        = r_fill + ONE_C;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_final_item) begin
                        n_state = ST_EMIT;
                        n_left  = n_fill;
                    end
                end
            end
            ST_EMIT: begin
                o_valid      = 1'b1;
                w_ctrl.shift = 1'b1;
                n_left       = r_left - ONE_C;
                if (r_left == ONE_C) begin
                    n_state = ST_LOAD;
                    n_fill  = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_left  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_drop  <= n_drop;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SORT_DEPTH; g++) begin : g_cell
            t_link w_l;
            t_link w_r;
            if (g == 0) begin : g_head
                assign w_l = '{valid: 1'b0, gt: 1'b0, data: '0};
            end else begin : g_mid
                assign w_l = w_link[g-1];
            end
            if (g == SORT_DEPTH - 1) begin : g_tail
                assign w_r = '{valid: 1'b0, gt: 1'b1, data: '0};
            end else begin : g_body
                assign w_r = w_link[g+1];
            end
            mss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_l),
                .i_right (w_r),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    assign o_sorted_value = w_link[0].data;
    assign o_end_of_run   = (r_left == ONE_C);
    assign o_overflow     = r_drop;

endmodule : merge_sorter
`default_nettype wire

/* hw/rtl/mss_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_cell: one slot of the sorted chain
// Insert: the first slot above the new key takes it, slots past it take
// their left neighbor. Shift: every slot takes its right neighbor.
// ----------------------------------------------------------------------------
module mss_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire mss_pkg::t_cell_ctrl i_ctrl,
    input  wire mss_pkg::t_link      i_left,
    input  wire mss_pkg::t_link      i_right,
    output mss_pkg::t_link       o_link
);
    import mss_pkg::*;

    logic  r_valid;
    t_data r_data;
    logic  n_valid;
    t_data n_data;
    logic  w_gt;

    // ties keep the older key first: only a strictly greater key is passed
    assign w_gt = !r_valid || ($signed(r_data) > $signed(i_ctrl.data));

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_data  = i_right.data;
        end else if (i_ctrl.insert && w_gt) begin
            if (i_left.gt) begin
                n_valid = i_left.valid;
                n_data  = i_left.data;
            end else begin
                n_valid = 1'b1;
                n_data  = i_ctrl.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.data  = r_data;

endmodule : mss_cell
`default_nettype wire

/* hw/rtl/mss_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_checker: port-level checks for the merge sorter
// Results appear only while busy, come as one unbroken burst after a final
// transaction and end with exactly one end-of-run marker.
// ----------------------------------------------------------------------------
module mss_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire         i_final_item,
    input  wire         o_valid,
    input  wire         o_end_of_run,
    input  wire         o_overflow
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside busy window");

    a_final_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_final_item) |=> o_valid)
        else $error("no result after final transaction");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_end_of_run) |=> (o_valid && $stable(o_overflow)))
        else $error("result burst broken");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_run) |=> (!o_valid && !busy))
        else $error("result after end of run");

endmodule : mss_checker

bind merge_sorter mss_checker u_mss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_final_item (i_final_item),
    .o_valid      (o_valid),
    .o_end_of_run (o_end_of_run),
    .o_overflow   (o_overflow)
);
`default_nettype wire
